// File: rtl/tuet_pkg.sv
// shared types and constants for the thread unit event tally
`default_nettype none

package tuet_pkg;

    // table geometry
    localparam int TABLE_ENTRIES = 64;
    localparam int ID_BITS       = 22;
    localparam int SLOT_BITS     = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

    // item field widths
    localparam int TID_W   = 22;
    localparam int CALL_W  = 10;
    localparam int ARG_W   = 64;
    localparam int CNT_W   = 32;
    localparam int STS_W   = 5;

    // marker call and codes
    localparam logic [CALL_W-1:0] MARK_CALL    = 10'd62;
    localparam logic [ARG_W-1:0]  CODE_ENTRY   = 64'h0000_0000_ffff_ff9c;
    localparam logic [ARG_W-1:0]  CODE_EXIT    = 64'h0000_0000_ffff_ff9b;
    localparam logic [ARG_W-1:0]  CODE_READ_A  = 64'h0000_0000_ffff_ff38;
    localparam logic [ARG_W-1:0]  CODE_READ_B  = 64'h0000_0000_ffff_ff37;
    localparam logic [ARG_W-1:0]  CODE_WRITE_A = 64'h0000_0000_ffff_fed4;
    localparam logic [ARG_W-1:0]  CODE_WRITE_B = 64'h0000_0000_ffff_fed3;

    // per-thread status bits
    localparam logic [STS_W-1:0] STS_ENTERED = 5'h01;
    localparam logic [STS_W-1:0] STS_EXITED  = 5'h02;
    localparam logic [STS_W-1:0] STS_MWRITE  = 5'h04;
    localparam logic [STS_W-1:0] STS_MREAD   = 5'h08;
    localparam logic [STS_W-1:0] STS_CALL    = 5'h10;
    localparam logic [STS_W-1:0] STS_ACTIVE  = STS_MWRITE | STS_MREAD | STS_CALL;

    // counter slots
    localparam int TL_ENTRY       = 0;
    localparam int TL_EXIT        = 1;
    localparam int TL_READ        = 2;
    localparam int TL_WRITE       = 3;
    localparam int TL_PLAIN       = 4;
    localparam int TL_IDLE_ENTRY  = 5;
    localparam int TL_IDLE_EXIT   = 6;
    localparam int TL_STRAY_READ  = 7;
    localparam int TL_STRAY_WRITE = 8;
    localparam int N_TALLIES      = 9;

    typedef enum logic [2:0] {
        EV_ENTRY,
        EV_EXIT,
        EV_READ,
        EV_WRITE,
        EV_PLAIN
    } t_event;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOK,
        S_UPD
    } t_state;

    typedef struct packed {
        logic [TID_W-1:0]  thread_id;
        logic [CALL_W-1:0] call_number;
        logic [ARG_W-1:0]  first_arg;
    } t_in_item;

    typedef struct packed {
        logic [CNT_W-1:0] entry_count;
        logic [CNT_W-1:0] exit_count;
        logic [CNT_W-1:0] read_count;
        logic [CNT_W-1:0] write_count;
        logic [CNT_W-1:0] plain_call_count;
        logic [CNT_W-1:0] idle_entry_count;
        logic [CNT_W-1:0] idle_exit_count;
        logic [CNT_W-1:0] stray_read_count;
        logic [CNT_W-1:0] stray_write_count;
        logic             table_full;
    } t_out_item;

    // controller to datapath
    typedef struct packed {
        logic load_in;
        logic lookup;
        logic update;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic out_busy;
    } t_dp_status;

endpackage

`default_nettype wire

// File: rtl/tuet_ram.sv
// generic single write port ram with registered read
`default_nettype none

module tuet_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                                       i_clk,
    input  wire logic                                       i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                           i_wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                           o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// File: rtl/tuet_ctrl.sv
// sequencing state machine: accept, look up, update
`default_nettype none

module tuet_ctrl (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire tuet_pkg::t_dp_status i_status,
    output tuet_pkg::t_dp_cmd         o_cmd
);
    import tuet_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_LOOK;
                end
            end
            S_LOOK: n_state = S_UPD;
            S_UPD: begin
                if (!i_status.out_busy) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_stall    = 1'b1;
        o_cmd.load_in = 1'b0;
        o_cmd.lookup  = 1'b0;
        o_cmd.update  = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_stall    = 1'b0;
                o_cmd.load_in = i_in_valid;
            end
            S_LOOK: o_cmd.lookup = 1'b1;
            S_UPD:  o_cmd.update = !i_status.out_busy;
            default: o_in_stall = 1'b1;
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/tuet_dp.sv
// datapath: thread key table, status ram, counters, output register
`default_nettype none

module tuet_dp (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire tuet_pkg::t_in_item   i_in_item,
    input  wire tuet_pkg::t_dp_cmd    i_cmd,
    output tuet_pkg::t_dp_status      o_status,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output tuet_pkg::t_out_item       o_out_item
);
    import tuet_pkg::*;

    t_in_item               r_item;
    logic [ID_BITS-1:0]     r_keys [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0] r_valid;
    logic [SLOT_BITS-1:0]   r_slot;
    logic                   r_hit;
    logic                   r_full;
    logic [CNT_W-1:0]       r_tally [N_TALLIES];
    logic [CNT_W-1:0]       n_tally [N_TALLIES];
    logic                   r_out_valid;
    t_out_item              r_out;

    logic [ID_BITS-1:0]       key;
    logic [TABLE_ENTRIES-1:0] hit_vec;
    logic [SLOT_BITS-1:0]     hit_idx;
    logic [SLOT_BITS-1:0]     free_idx;
    logic                     any_hit;
    logic                     any_free;
    logic [STS_W-1:0]         ram_rdata;
    logic [STS_W-1:0]         st_cur;
    logic [STS_W-1:0]         st_new;
    logic [N_TALLIES-1:0]     bump;
    t_event                   evt;
    logic                     cur_idle;

    // lowest set bit
    function automatic logic [SLOT_BITS-1:0] first_set(input logic [TABLE_ENTRIES-1:0] v);
        logic [SLOT_BITS-1:0] idx;
        idx = '0;
        for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
            if (v[i]) begin
                idx = SLOT_BITS'(i);
            end
        end
        return idx;
    endfunction

    assign key = ID_BITS'(r_item.thread_id);

    always_comb begin
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            hit_vec[i] = r_valid[i] && (r_keys[i] == key);
        end
    end

    assign any_hit  = |hit_vec;
    assign any_free = ~&r_valid;
    assign hit_idx  = first_set(hit_vec);
    assign free_idx = first_set(~r_valid);

    tuet_ram #(
        .WIDTH (STS_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_status_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.update && !r_full),
        .i_waddr (r_slot),
        .i_wdata (st_new),
        .i_raddr (hit_idx),
        .o_rdata (ram_rdata)
    );

    // input capture, lookup result, key table
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_item <= i_in_item;
        end
        if (i_cmd.lookup) begin
            r_hit  <= any_hit;
            r_full <= !any_hit && !any_free;
            r_slot <= any_hit ? hit_idx : free_idx;
            if (!any_hit && any_free) begin
                r_keys[free_idx] <= key;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_cmd.lookup && !any_hit && any_free) begin
            r_valid[free_idx] <= 1'b1;
        end
    end

    // event decode
    always_comb begin
        evt = EV_PLAIN;
        if (r_item.call_number == MARK_CALL) begin
            if (r_item.first_arg == CODE_ENTRY) begin
                evt = EV_ENTRY;
            end else if (r_item.first_arg == CODE_EXIT) begin
                evt = EV_EXIT;
            end else if (r_item.first_arg == CODE_READ_A ||
                         r_item.first_arg == CODE_READ_B) begin
                evt = EV_READ;
            end else if (r_item.first_arg == CODE_WRITE_A ||
                         r_item.first_arg == CODE_WRITE_B) begin
                evt = EV_WRITE;
            end
        end
    end

    // new or unstored threads start from zero status
    assign st_cur   = r_hit ? ram_rdata : '0;
    assign cur_idle = ((st_cur & STS_ENTERED) != '0) && ((st_cur & STS_ACTIVE) == '0);

    always_comb begin
        bump   = '0;
        st_new = st_cur;
        case (evt)
            EV_ENTRY: begin
                bump[TL_ENTRY]      = 1'b1;
                bump[TL_IDLE_ENTRY] = cur_idle;
                st_new              = STS_ENTERED;
            end
            EV_EXIT: begin
                if (st_cur == '0) begin
                    bump[TL_IDLE_EXIT] = 1'b1;
                end else if (cur_idle) begin
                    bump[TL_IDLE_ENTRY] = 1'b1;
                    bump[TL_IDLE_EXIT]  = 1'b1;
                end
                bump[TL_EXIT] = 1'b1;
                st_new        = STS_EXITED;
            end
            EV_READ: begin
                bump[TL_READ]       = 1'b1;
                bump[TL_STRAY_READ] = (st_cur & STS_ENTERED) == '0;
                st_new              = st_cur | STS_MREAD;
            end
            EV_WRITE: begin
                bump[TL_WRITE]       = 1'b1;
                bump[TL_STRAY_WRITE] = (st_cur & STS_ENTERED) == '0;
                st_new               = st_cur | STS_MWRITE;
            end
            EV_PLAIN: begin
                bump[TL_PLAIN] = 1'b1;
                st_new         = st_cur | STS_CALL;
            end
            default: begin
                bump[TL_PLAIN] = 1'b1;
                st_new         = st_cur | STS_CALL;
            end
        endcase
    end

    // saturating counters
    always_comb begin
        for (int i = 0; i < N_TALLIES; i++) begin
            n_tally[i] = (bump[i] && (r_tally[i] != '1)) ? r_tally[i] + 1'b1 : r_tally[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < N_TALLIES; i++) begin
                r_tally[i] <= '0;
            end
        end else if (i_cmd.update) begin
            for (int i = 0; i < N_TALLIES; i++) begin
                r_tally[i] <= n_tally[i];
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.update) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.update) begin
            r_out.entry_count       <= n_tally[TL_ENTRY];
            r_out.exit_count        <= n_tally[TL_EXIT];
            r_out.read_count        <= n_tally[TL_READ];
            r_out.write_count       <= n_tally[TL_WRITE];
            r_out.plain_call_count  <= n_tally[TL_PLAIN];
            r_out.idle_entry_count  <= n_tally[TL_IDLE_ENTRY];
            r_out.idle_exit_count   <= n_tally[TL_IDLE_EXIT];
            r_out.stray_read_count  <= n_tally[TL_STRAY_READ];
            r_out.stray_write_count <= n_tally[TL_STRAY_WRITE];
            r_out.table_full        <= r_full;
        end
    end

    assign o_status.out_busy = r_out_valid && i_out_stall;
    assign o_out_valid       = r_out_valid;
    assign o_out_item        = r_out;

endmodule

`default_nettype wire

// File: rtl/thread_unit_event_tally.sv
// top level of the per-thread unit event tally
// flow: the accept edge captures the item, the lookup edge registers the table result and
//   reads the status ram (registered read), and the update edge writes counters and result;
//   a new item is taken only back in idle; the update is held while a result waits on output stall
// reset: synchronous active low; clears thread valid bits, all nine counters,
//   the controller state and the output valid flag
`default_nettype none

module thread_unit_event_tally (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    // event items in
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire tuet_pkg::t_in_item  i_in_item,
    // count items out
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output tuet_pkg::t_out_item      o_out_item
);
    import tuet_pkg::*;

    // command and status between sequencer and datapath
    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;

    // sequencer: stalls the input outside idle, holds the update
    // while the previous result is still stalled at the output
    tuet_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (dp_status),
        .o_cmd      (dp_cmd)
    );

    // datapath: associative thread table with first-free allocation,
    // status ram, marker decode, saturating counters and result register
    tuet_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_item   (i_in_item),
        .i_cmd       (dp_cmd),
        .o_status    (dp_status),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

endmodule

`default_nettype wire
